// File: rtl/core/rlsd_pkg.sv
// rlsd_pkg: shared constants and word types for the LED matrix scan driver.
// Depends on nothing; imported by every module of the block except rlsd_ram.
package rlsd_pkg;

  localparam int ROWS_PER_SECTION   = 16;
  localparam int FIRST_PANEL_WIDTH  = 32;
  localparam int SECOND_PANEL_WIDTH = 32;
  localparam int PANEL_HEIGHT       = 32;
  localparam int FRAME_WORDS        = 4096;  // power of two, address wraps by truncation
  localparam int TOTAL_COLS         = FIRST_PANEL_WIDTH + SECOND_PANEL_WIDTH;

  localparam int ADDR_W   = $clog2(FRAME_WORDS);
  localparam int COLOR_W  = 3;
  localparam int SEC_W    = 4;
  localparam int COL_W    = 7;
  localparam int LIT_W    = 16;
  localparam int STRIDE_W = 7;
  localparam int TICKS_W  = 16;
  localparam int PADDR_W  = 3;
  localparam int PDATA_W  = 32;

  localparam logic [STRIDE_W-1:0] STRIDE_RESET = STRIDE_W'(32);
  localparam logic [TICKS_W-1:0]  TICKS_RESET  = TICKS_W'(100);

  localparam logic REG_LINE_STRIDE   = 1'b0;
  localparam logic REG_DISPLAY_TICKS = 1'b1;

  typedef struct packed {
    logic         mode;
    logic [11:0]  write_address;
    logic [2:0]   pixel_color;
  } item_t;

  typedef struct packed {
    logic [3:0] row_address;
    logic       upper_red;
    logic       upper_green;
    logic       upper_blue;
    logic       lower_red;
    logic       lower_green;
    logic       lower_blue;
    logic       shift_clock;
    logic       latch_pulse;
    logic       display_enable;
    logic       frame_done;
  } result_t;

  typedef struct packed {
    logic [SEC_W-1:0] row_address;
    logic             shift_clock;
    logic             latch_pulse;
    logic             display_enable;
    logic             frame_done;
  } scan_ctrl_t;

  typedef struct packed {
    logic               is_tick;
    logic [ADDR_W-1:0]  waddr;
    logic [COLOR_W-1:0] color;
    logic [ADDR_W-1:0]  addr_up;
    logic [ADDR_W-1:0]  addr_lo;
    scan_ctrl_t         ctrl;
  } cmd_t;

endpackage

// File: rtl/core/rlsd_ram.sv
// rlsd_ram: generic RAM, one write port and two registered read ports.
// Depends on nothing.
module rlsd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// File: rtl/core/rlsd_front.sv
// rlsd_front: accepts input words, runs the scan sequencer and turns each word
// into a command for the back end. Depends on rlsd_pkg.
module rlsd_front (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            item_valid,
  output logic                            item_ready,
  input  rlsd_pkg::item_t                 item,
  input  logic [rlsd_pkg::STRIDE_W-1:0]   line_stride,
  input  logic [rlsd_pkg::TICKS_W-1:0]    display_ticks,
  input  logic                            busy,
  output logic                            push_valid,
  input  logic                            push_ready,
  output rlsd_pkg::cmd_t                  push_cmd
);
  import rlsd_pkg::*;

  localparam logic [1:0] PH_SHIFT = 2'd0;
  localparam logic [1:0] PH_LATCH = 2'd1;
  localparam logic [1:0] PH_LIT   = 2'd2;

  logic [SEC_W-1:0] sec, sec_next;
  logic [COL_W-1:0] col, col_next;
  logic [1:0]       phase, phase_next;
  logic [LIT_W-1:0] lit, lit_next;

  logic [TICKS_W-1:0] ticks_eff;
  logic [COL_W-1:0]   col_eff;
  logic [ADDR_W-1:0]  row_up, row_lo;
  logic               accept;

  assign item_ready = push_ready && !busy;
  assign accept     = item_valid && item_ready;
  assign push_valid = accept;
  assign ticks_eff  = (display_ticks == '0) ? TICKS_W'(1) : display_ticks;

  always_comb begin
    if ({1'b0, col} < (COL_W+1)'(FIRST_PANEL_WIDTH)) begin
      col_eff = col;
      row_up  = ADDR_W'(sec);
    end else begin
      col_eff = col - COL_W'(FIRST_PANEL_WIDTH);
      row_up  = ADDR_W'(sec) + ADDR_W'(PANEL_HEIGHT);
    end
    row_lo = row_up + ADDR_W'(ROWS_PER_SECTION);
  end

  always_comb begin
    sec_next   = sec;
    col_next   = col;
    phase_next = phase;
    lit_next   = lit;

    push_cmd                      = '0;
    push_cmd.is_tick              = item.mode;
    push_cmd.waddr                = ADDR_W'(item.write_address);
    push_cmd.color                = item.pixel_color;
    push_cmd.addr_up              = row_up * ADDR_W'(line_stride) + ADDR_W'(col_eff);
    push_cmd.addr_lo              = row_lo * ADDR_W'(line_stride) + ADDR_W'(col_eff);
    push_cmd.ctrl.row_address     = sec;

    if (item.mode) begin
      unique case (phase)
        PH_LATCH: begin
          push_cmd.ctrl.latch_pulse = 1'b1;
          phase_next = PH_LIT;
          lit_next   = '0;
        end
        PH_LIT: begin
          push_cmd.ctrl.display_enable = 1'b1;
          if ((LIT_W+1)'(lit) + (LIT_W+1)'(1) >= (LIT_W+1)'(ticks_eff)) begin
            if ((SEC_W+1)'(sec) + (SEC_W+1)'(1) >= (SEC_W+1)'(ROWS_PER_SECTION)) begin
              push_cmd.ctrl.frame_done = 1'b1;
              sec_next = '0;
            end else begin
              sec_next = sec + SEC_W'(1);
            end
            lit_next   = '0;
            col_next   = '0;
            phase_next = PH_SHIFT;
          end else begin
            lit_next = lit + LIT_W'(1);
          end
        end
        default: begin
          push_cmd.ctrl.shift_clock = 1'b1;
          if ((COL_W+1)'(col) + (COL_W+1)'(1) >= (COL_W+1)'(TOTAL_COLS)) begin
            col_next   = '0;
            phase_next = PH_LATCH;
          end else begin
            col_next   = col + COL_W'(1);
            phase_next = PH_SHIFT;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sec   <= '0;
      col   <= '0;
      phase <= PH_SHIFT;
      lit   <= '0;
    end else if (accept) begin
      sec   <= sec_next;
      col   <= col_next;
      phase <= phase_next;
      lit   <= lit_next;
    end
  end

endmodule

// File: rtl/core/rlsd_cmd_queue.sv
// rlsd_cmd_queue: two-entry command queue between front and back end.
// Depends on rlsd_pkg.
module rlsd_cmd_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push_valid,
  output logic           push_ready,
  input  rlsd_pkg::cmd_t push_cmd,
  output logic           pop_valid,
  input  logic           pop_ready,
  output rlsd_pkg::cmd_t pop_cmd
);
  import rlsd_pkg::*;

  cmd_t       entry [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;
  logic       do_push, do_pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_cmd    = entry[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= !wr_ptr;
      if (do_pop)  rd_ptr <= !rd_ptr;
      count <= count + 2'(do_push) - 2'(do_pop);
    end
  end

endmodule

// File: rtl/core/rlsd_back.sv
// rlsd_back: frame store, clearing pass, pixel fetch and result queue.
// Depends on rlsd_pkg and rlsd_ram.
module rlsd_back (
  input  logic              clk,
  input  logic              rst,
  output logic              busy,
  input  logic              cmd_valid,
  output logic              cmd_ready,
  input  rlsd_pkg::cmd_t    cmd,
  output logic              result_valid,
  input  logic              result_ready,
  output rlsd_pkg::result_t result
);
  import rlsd_pkg::*;

  localparam int RES_DEPTH = 4;
  localparam int RPTR_W    = $clog2(RES_DEPTH);

  logic              clearing;
  logic [ADDR_W-1:0] clr_addr;

  logic               ram_we;
  logic [ADDR_W-1:0]  ram_waddr;
  logic [COLOR_W-1:0] ram_wdata;
  logic [COLOR_W-1:0] up, lo;

  logic       s1_valid;
  scan_ctrl_t s1_ctrl;

  result_t           res_mem [RES_DEPTH];
  logic [RPTR_W-1:0] wr_ptr, rd_ptr;
  logic [RPTR_W:0]   res_count;
  logic              room, do_pop, res_push, res_pop;
  result_t           res_in;

  assign busy      = clearing;
  assign room      = (res_count + (RPTR_W+1)'(s1_valid)) < (RPTR_W+1)'(RES_DEPTH);
  assign cmd_ready = !clearing && (!cmd.is_tick || room);
  assign do_pop    = cmd_valid && cmd_ready;

  assign ram_we    = clearing || (do_pop && !cmd.is_tick);
  assign ram_waddr = clearing ? clr_addr : cmd.waddr;
  assign ram_wdata = clearing ? '0 : cmd.color;

  rlsd_ram #(
    .WIDTH (COLOR_W),
    .DEPTH (FRAME_WORDS)
  ) u_frame_store (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .raddr_a (cmd.addr_up),
    .raddr_b (cmd.addr_lo),
    .rdata_a (up),
    .rdata_b (lo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + ADDR_W'(1);
      if (clr_addr == ADDR_W'(FRAME_WORDS - 1)) clearing <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= do_pop && cmd.is_tick;
    end
    s1_ctrl <= cmd.ctrl;
  end

  always_comb begin
    res_in                = '0;
    res_in.row_address    = s1_ctrl.row_address;
    res_in.shift_clock    = s1_ctrl.shift_clock;
    res_in.latch_pulse    = s1_ctrl.latch_pulse;
    res_in.display_enable = s1_ctrl.display_enable;
    res_in.frame_done     = s1_ctrl.frame_done;
    if (s1_ctrl.shift_clock) begin
      res_in.upper_red   = up[0];
      res_in.upper_green = up[1];
      res_in.upper_blue  = up[2];
      res_in.lower_red   = lo[0];
      res_in.lower_green = lo[1];
      res_in.lower_blue  = lo[2];
    end
  end

  assign res_push     = s1_valid;
  assign result_valid = (res_count != '0);
  assign result       = res_mem[rd_ptr];
  assign res_pop      = result_valid && result_ready;

  always_ff @(posedge clk) begin
    if (res_push) begin
      res_mem[wr_ptr] <= res_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr    <= '0;
      rd_ptr    <= '0;
      res_count <= '0;
    end else begin
      if (res_push) wr_ptr <= wr_ptr + RPTR_W'(1);
      if (res_pop)  rd_ptr <= rd_ptr + RPTR_W'(1);
      res_count <= res_count + (RPTR_W+1)'(res_push) - (RPTR_W+1)'(res_pop);
    end
  end

endmodule

// File: rtl/core/rgb_led_matrix_scan_driver.sv
// Scan driver for two chained half-scan RGB LED panels sharing one frame store.
// Takes one word per clock (pixel write or scan tick) while no clearing pass runs and the
// command queue has room; each tick gives one pin-state word. After reset the frame store
// is swept to black, one entry per cycle, all 4096 entries; no words are taken meanwhile.
// The frame store's single write port and dual read port set the one-word-per-cycle rate.
// Depends on rlsd_pkg, rlsd_front, rlsd_cmd_queue, rlsd_back, rlsd_ram.
module rgb_led_matrix_scan_driver (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           item_valid,
  output logic                           item_ready,
  input  rlsd_pkg::item_t                item,
  output logic                           result_valid,
  input  logic                           result_ready,
  output rlsd_pkg::result_t              result,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [rlsd_pkg::PADDR_W-1:0]   paddr,
  input  logic [rlsd_pkg::PDATA_W-1:0]   pwdata,
  output logic [rlsd_pkg::PDATA_W-1:0]   prdata,
  output logic                           pready
);
  import rlsd_pkg::*;

  logic [STRIDE_W-1:0] line_stride;
  logic [TICKS_W-1:0]  display_ticks;
  logic                busy;
  logic                push_valid, push_ready;
  logic                pop_valid, pop_ready;
  cmd_t                push_cmd, pop_cmd;
  logic                cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_stride   <= STRIDE_RESET;
      display_ticks <= TICKS_RESET;
    end else if (cfg_write) begin
      unique case (paddr[2])
        REG_LINE_STRIDE:   line_stride   <= pwdata[STRIDE_W-1:0];
        REG_DISPLAY_TICKS: display_ticks <= pwdata[TICKS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_LINE_STRIDE:   prdata = PDATA_W'(line_stride);
      REG_DISPLAY_TICKS: prdata = PDATA_W'(display_ticks);
      default:           prdata = '0;
    endcase
  end

  rlsd_front u_front (
    .clk           (clk),
    .rst           (rst),
    .item_valid    (item_valid),
    .item_ready    (item_ready),
    .item          (item),
    .line_stride   (line_stride),
    .display_ticks (display_ticks),
    .busy          (busy),
    .push_valid    (push_valid),
    .push_ready    (push_ready),
    .push_cmd      (push_cmd)
  );

  rlsd_cmd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_cmd    (pop_cmd)
  );

  rlsd_back u_back (
    .clk          (clk),
    .rst          (rst),
    .busy         (busy),
    .cmd_valid    (pop_valid),
    .cmd_ready    (pop_ready),
    .cmd          (pop_cmd),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule

// File: verif/tb_top.sv
// Testbench for the LED matrix scan driver: pixel writes and scan ticks go in and every
// pin-state word that comes back is compared with a local model of the scan.
// Depends on rlsd_pkg and the rgb_led_matrix_scan_driver RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import rlsd_pkg::*;

  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_TICK  = 1'b1;
  localparam logic [PADDR_W-1:0] ADDR_STRIDE = PADDR_W'(4 * REG_LINE_STRIDE);
  localparam logic [PADDR_W-1:0] ADDR_TICKS  = PADDR_W'(4 * REG_DISPLAY_TICKS);
  localparam int CYCLE_LIMIT  = 400000;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 16;

  typedef enum logic [1:0] {SCAN_SHIFT, SCAN_LATCH, SCAN_LIT, SCAN_SPARE} scan_ph_e;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                item_valid = 1'b0;
  logic                item_ready;
  item_t               item = '0;
  logic                result_valid;
  logic                result_ready = 1'b0;
  result_t             result;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [PADDR_W-1:0]  paddr = '0;
  logic [PDATA_W-1:0]  pwdata = '0;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;

  rgb_led_matrix_scan_driver dut (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_ready(item_ready), .item(item),
    .result_valid(result_valid), .result_ready(result_ready), .result(result),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // scan model state
  logic [COLOR_W-1:0]  pixel_mem [FRAME_WORDS];
  logic [STRIDE_W-1:0] stride_cfg = STRIDE_RESET;
  logic [TICKS_W-1:0]  ticks_cfg = TICKS_RESET;
  scan_ph_e            scan_ph = SCAN_SHIFT;
  int                  sec_q = 0;
  int                  col_q = 0;
  int                  lit_q = 0;
  result_t             pins_expected [$];

  int  err_count = 0;
  int  cycle_count = 0;
  int  hold_count = 0;
  int  hold_served = 0;
  int  hold_left = 0;
  int  stall_pattern = 0;
  int  burst_left = 0;
  bit  sender_gaps = 1'b1;
  result_t pins_front;

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout", $time);
      $display("FAILED: results differ");
      $finish;
    end
  end

  // receiver: stall pattern redrawn at random from three patterns, long hold-off on request
  always @(posedge clk) begin
    if (cycle_count % 128 == 0) stall_pattern <= $urandom_range(0, 2);
    if (hold_left != 0) begin
      result_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_served != hold_count) begin
      hold_served <= hold_count;
      hold_left <= HOLD_CYCLES;
      result_ready <= 1'b0;
    end else begin
      case (stall_pattern)
        0: result_ready <= 1'b1;
        1: result_ready <= ($urandom_range(0, 3) != 0);
        default: result_ready <= (cycle_count % 8 != 5) && (cycle_count % 8 != 6);
      endcase
    end
  end

  function automatic logic [COLOR_W-1:0] pixel_at(int row, int col);
    return pixel_mem[(row * int'(stride_cfg) + col) % FRAME_WORDS];
  endfunction

  task automatic advance_scan(input item_t w);
    result_t r;
    logic [COLOR_W-1:0] up, lo;
    int col, ticks;
    if (w.mode == MODE_WRITE) begin
      pixel_mem[w.write_address] = w.pixel_color;
    end else begin
      r = '0;
      up = '0;
      lo = '0;
      r.row_address = SEC_W'(sec_q);
      case (scan_ph)
        SCAN_LATCH: begin
          r.latch_pulse = 1'b1;
          scan_ph = SCAN_LIT;
          lit_q = 0;
        end
        SCAN_LIT: begin
          ticks = (ticks_cfg == 0) ? 1 : int'(ticks_cfg);
          r.display_enable = 1'b1;
          if (lit_q + 1 >= ticks) begin
            if (sec_q + 1 >= ROWS_PER_SECTION) begin
              r.frame_done = 1'b1;
              sec_q = 0;
            end else begin
              sec_q = sec_q + 1;
            end
            lit_q = 0;
            col_q = 0;
            scan_ph = SCAN_SHIFT;
          end else begin
            lit_q = lit_q + 1;
          end
        end
        default: begin
          r.shift_clock = 1'b1;
          if (col_q < FIRST_PANEL_WIDTH) begin
            up = pixel_at(sec_q, col_q);
            lo = pixel_at(sec_q + ROWS_PER_SECTION, col_q);
          end else begin
            col = col_q - FIRST_PANEL_WIDTH;
            up = pixel_at(sec_q + PANEL_HEIGHT, col);
            lo = pixel_at(sec_q + PANEL_HEIGHT + ROWS_PER_SECTION, col);
          end
          if (col_q + 1 >= TOTAL_COLS) begin
            col_q = 0;
            scan_ph = SCAN_LATCH;
          end else begin
            col_q = col_q + 1;
            scan_ph = SCAN_SHIFT;
          end
        end
      endcase
      r.upper_red   = up[0];
      r.upper_green = up[1];
      r.upper_blue  = up[2];
      r.lower_red   = lo[0];
      r.lower_green = lo[1];
      r.lower_blue  = lo[2];
      pins_expected.push_back(r);
    end
  endtask

  task automatic check_field(input string name, input int e, input int a);
    if (e != a) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, e, a);
      err_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) begin
      if (pins_expected.size() == 0) begin
        $display("%0t: unexpected word, expected none actual %h", $time, result);
        err_count++;
      end else begin
        pins_front = pins_expected.pop_front();
        check_field("row_address", int'(pins_front.row_address), int'(result.row_address));
        check_field("upper_red", int'(pins_front.upper_red), int'(result.upper_red));
        check_field("upper_green", int'(pins_front.upper_green), int'(result.upper_green));
        check_field("upper_blue", int'(pins_front.upper_blue), int'(result.upper_blue));
        check_field("lower_red", int'(pins_front.lower_red), int'(result.lower_red));
        check_field("lower_green", int'(pins_front.lower_green), int'(result.lower_green));
        check_field("lower_blue", int'(pins_front.lower_blue), int'(result.lower_blue));
        check_field("shift_clock", int'(pins_front.shift_clock), int'(result.shift_clock));
        check_field("latch_pulse", int'(pins_front.latch_pulse), int'(result.latch_pulse));
        check_field("display_enable", int'(pins_front.display_enable),
                    int'(result.display_enable));
        check_field("frame_done", int'(pins_front.frame_done), int'(result.frame_done));
      end
    end
  end

  // sender: bursts of random length, optional gap in front of each burst
  task automatic send_word(input item_t w);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      if (sender_gaps) gap = $urandom_range(0, 6);
    end
    burst_left--;
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    item <= w;
    do @(posedge clk); while (!item_ready);
    advance_scan(w);
  endtask

  task automatic send_fields(input logic mode, input int addr, input int color);
    item_t w;
    w.mode = mode;
    w.write_address = 12'(addr);
    w.pixel_color = 3'(color);
    send_word(w);
  endtask

  task automatic run_words(input int n, input int tick_pct);
    item_t w;
    repeat (n) begin
      w.mode = ($urandom_range(0, 99) < tick_pct) ? MODE_TICK : MODE_WRITE;
      w.pixel_color = 3'($urandom_range(0, 7));
      if ($urandom_range(0, 1) != 0)
        w.write_address = 12'($urandom_range(0, 4095));
      else
        w.write_address = 12'($urandom_range(0, 63) * int'(stride_cfg) + $urandom_range(0, 31));
      send_word(w);
    end
  endtask

  task automatic wait_for_drain();
    item_valid <= 1'b0;
    while (pins_expected.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic read_reg(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] exp_val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= addr;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== exp_val) begin
      $display("%0t: register %0d readback, expected %h actual %h", $time, addr, exp_val, prdata);
      err_count++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // writes with junk in the unused upper bits, then reads back the masked value
  task automatic program_reg(input logic [PADDR_W-1:0] addr, input int field);
    logic [PDATA_W-1:0] mask, value;
    mask = (addr == ADDR_STRIDE) ? PDATA_W'({STRIDE_W{1'b1}}) : PDATA_W'({TICKS_W{1'b1}});
    value = ($urandom() & ~mask) | (PDATA_W'(field) & mask);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (addr == ADDR_STRIDE) stride_cfg = value[STRIDE_W-1:0];
    else ticks_cfg = value[TICKS_W-1:0];
    read_reg(addr, value & mask);
  endtask

  task automatic set_scan(input int stride, input int ticks);
    wait_for_drain();
    program_reg(ADDR_STRIDE, stride);
    program_reg(ADDR_TICKS, ticks);
  endtask

  task automatic test_reset_values();
    read_reg(ADDR_STRIDE, PDATA_W'(STRIDE_RESET));
    read_reg(ADDR_TICKS, PDATA_W'(TICKS_RESET));
  endtask

  // column 0 of all four row groups of section 0, plus corner addresses
  task automatic test_directed_pixels();
    send_fields(MODE_WRITE, 0, 7);
    send_fields(MODE_WRITE, ROWS_PER_SECTION * 32, 5);
    send_fields(MODE_WRITE, PANEL_HEIGHT * 32, 3);
    send_fields(MODE_WRITE, (PANEL_HEIGHT + ROWS_PER_SECTION) * 32, 6);
    send_fields(MODE_WRITE, 1, 2);
    send_fields(MODE_WRITE, ROWS_PER_SECTION * 32 + 1, 4);
    send_fields(MODE_WRITE, 2, 1);
    send_fields(MODE_WRITE, 4095, 7);
    send_fields(MODE_WRITE, 4095, 0);
    send_fields(MODE_WRITE, 12'hAAA, 5);
    send_fields(MODE_WRITE, 12'h555, 2);
    send_fields(MODE_TICK, 0, 0);
    send_fields(MODE_TICK, 4095, 7);
    send_fields(MODE_TICK, 12'hAAA, 5);
    send_fields(MODE_WRITE, 3, 0);
    send_fields(MODE_TICK, 12'h555, 2);
  endtask

  task automatic test_frame_sweep();
    set_scan(32, 0);
    sender_gaps = 1'b0;
    run_words(200, 90);
    sender_gaps = 1'b1;
    run_words(200, 90);
  endtask

  task automatic test_stride_extremes();
    set_scan(0, 1);
    run_words(120, 80);
    set_scan(127, 2);
    run_words(120, 80);
    set_scan(64, 1);
    run_words(120, 80);
    set_scan(1, 3);
    run_words(80, 80);
  endtask

  task automatic test_long_display();
    set_scan(32, 65535);
    run_words(80, 85);
    set_scan(32, 100);
    run_words(80, 85);
  endtask

  task automatic test_backpressure();
    set_scan(32, 2);
    hold_count++;
    sender_gaps = 1'b0;
    run_words(200, 100);
    sender_gaps = 1'b1;
  endtask

  task automatic test_random_settings();
    repeat (4) begin
      set_scan($urandom_range(0, 127), $urandom_range(0, 8));
      run_words(60, 85);
    end
  endtask

  initial begin
    for (int i = 0; i < FRAME_WORDS; i++) pixel_mem[i] = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_values();
    while (!item_ready) @(posedge clk);
    test_directed_pixels();
    test_frame_sweep();
    test_stride_extremes();
    test_long_display();
    test_backpressure();
    test_random_settings();
    wait_for_drain();
    if (err_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
